// ----- rtl/core/hve_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants shared by the heightfield vertex encoder.
// No dependencies; every other file of the block imports this package.
package hve_pkg;

  localparam int HEIGHT_W = 24;
  localparam int DIFF_W   = 25;
  localparam int CODE_W   = 16;
  localparam int REG_W    = 32;
  localparam int CFG_IDX_W = 8;
  localparam int NORM_W   = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_SCALE  = 8'd1;

  localparam logic [REG_W-1:0] HEIGHT_SCALE_RST = 32'd16777216;
  localparam logic [REG_W-1:0] SLOPE_SCALE_RST  = 32'd32768;

  localparam logic [NORM_W-1:0] NORM_MAX  = 15'd32767;
  localparam logic [CODE_W-1:0] CODE_MAX  = 16'hFFFF;
  // Four times the square of the normal scale.
  localparam logic [REG_W-1:0]  FOUR_K2   = 32'd4294705156;
  localparam logic [3:0]        TOP_BIT   = 4'd14;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HMUL, ST_HCODE, ST_NMAG, ST_NSQ, ST_ND2,
    ST_NT2, ST_NPLO, ST_NPHI, ST_NCMP, ST_NEND, ST_FIN
  } hve_state_t;

  typedef enum logic [2:0] {
    OP_HEIGHT, OP_SLOPE, OP_SQ_D, OP_SQ_T, OP_A_LO, OP_A_HI
  } hve_op_t;

  typedef struct packed {
    logic    in_ready;
    logic    load_in;
    hve_op_t op;
    logic    cap_hcode;
    logic    cap_sat;
    logic    cap_d2;
    logic    cap_tsq;
    logic    cap_plo;
    logic    cmp_step;
    logic    end_axis;
    logic    load_out;
  } hve_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic prod_sat;
    logic last_bit;
    logic axis;
    logic out_free;
  } hve_status_t;

endpackage

// ----- rtl/core/hve_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the heightfield vertex encoder: vertex, result, config.
// Depends on hve_pkg for field widths.
interface hve_vtx_if;
  import hve_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] center_height;
  logic signed [HEIGHT_W-1:0] left_height;
  logic signed [HEIGHT_W-1:0] right_height;
  logic signed [HEIGHT_W-1:0] up_height;
  logic signed [HEIGHT_W-1:0] down_height;
  logic                       first_vertex;
  modport source (output valid, center_height, left_height, right_height, up_height,
                  down_height, first_vertex, input ready);
  modport sink (input valid, center_height, left_height, right_height, up_height,
                down_height, first_vertex, output ready);
endinterface

interface hve_res_if;
  import hve_pkg::*;
  logic                       valid;
  logic                       ready;
  logic        [CODE_W-1:0]   height_code;
  logic signed [CODE_W-1:0]   normal_x;
  logic signed [CODE_W-1:0]   normal_y;
  logic signed [HEIGHT_W-1:0] sector_min_height;
  logic signed [HEIGHT_W-1:0] sector_max_height;
  modport source (output valid, height_code, normal_x, normal_y, sector_min_height,
                  sector_max_height, input ready);
  modport sink (input valid, height_code, normal_x, normal_y, sector_min_height,
                sector_max_height, output ready);
endinterface

interface hve_cfg_if;
  import hve_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/hve_mul.sv -----
`timescale 1ns / 1ps
// Shared 32 by 32 unsigned multiplier with a registered product.
// Uses hve_pkg for the operand width.
module hve_mul (
  input  logic                         clk,
  input  logic [hve_pkg::REG_W-1:0]    a,
  input  logic [hve_pkg::REG_W-1:0]    b,
  output logic [2*hve_pkg::REG_W-1:0]  prod
);
  import hve_pkg::*;

  always_ff @(posedge clk) begin
    prod <= {{REG_W{1'b0}}, a} * {{REG_W{1'b0}}, b};
  end

endmodule

// ----- rtl/core/hve_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the encoder: steps the shared multiplier through the height
// product and the bitwise search of both normal terms. Uses hve_pkg.
module hve_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  hve_pkg::hve_status_t status,
  output hve_pkg::hve_ctrl_t   ctrl
);
  import hve_pkg::*;

  hve_state_t state;
  hve_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (status.in_valid) state_next = ST_HMUL;
      ST_HMUL:  state_next = ST_HCODE;
      ST_HCODE: state_next = ST_NMAG;
      ST_NMAG:  state_next = ST_NSQ;
      ST_NSQ:   state_next = status.prod_sat ? ST_NEND : ST_ND2;
      ST_ND2:   state_next = ST_NPLO;
      ST_NT2:   state_next = ST_NPLO;
      ST_NPLO:  state_next = ST_NPHI;
      ST_NPHI:  state_next = ST_NCMP;
      ST_NCMP:  state_next = status.last_bit ? ST_NEND : ST_NT2;
      ST_NEND:  state_next = status.axis ? ST_FIN : ST_NMAG;
      ST_FIN:   if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.op = OP_HEIGHT;
    case (state)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.load_in  = status.in_valid;
      end
      ST_HMUL:  ctrl.op = OP_HEIGHT;
      ST_HCODE: ctrl.cap_hcode = 1'b1;
      ST_NMAG:  ctrl.op = OP_SLOPE;
      ST_NSQ: begin
        ctrl.cap_sat = 1'b1;
        ctrl.op      = OP_SQ_D;
      end
      ST_ND2: begin
        ctrl.cap_d2 = 1'b1;
        ctrl.op     = OP_SQ_T;
      end
      ST_NT2: ctrl.op = OP_SQ_T;
      ST_NPLO: begin
        ctrl.cap_tsq = 1'b1;
        ctrl.op      = OP_A_LO;
      end
      ST_NPHI: begin
        ctrl.cap_plo = 1'b1;
        ctrl.op      = OP_A_HI;
      end
      ST_NCMP: ctrl.cmp_step = 1'b1;
      ST_NEND: ctrl.end_axis = 1'b1;
      ST_FIN:  ctrl.load_out = status.out_free;
      default: ctrl.op = OP_HEIGHT;
    endcase
  end

endmodule

// ----- rtl/core/heightfield_vertex_encoder.sv -----
`timescale 1ns / 1ps
// Heightfield vertex encoder: height code, two normal terms and the sector
// height range for each vertex. Uses hve_pkg, hve_if, hve_mul and hve_ctrl.
//
// The vertex channel takes one beat holding the centre height, the four
// neighbour heights and the first-vertex flag. The result channel gives one
// beat per vertex with the height code, the two normal terms and the running
// minimum and maximum of the sector. The configuration channel is always
// ready and writes height_scale at index 0 and slope_scale at index 1; other
// indexes are ignored.
// All arithmetic runs through one 32 by 32 multiplier under a sequencer. Each
// normal term is found one bit at a time over 15 steps, each of which squares
// a candidate, forms the low and high products and compares; a saturated
// slope skips the search. The vertex channel is ready only while the
// sequencer is idle.
// The result sits in an output register; a new vertex is accepted while it
// waits, and a further result is held until the receiver takes the first.
// Reset restores the register defaults and clears the sector range to zero.
module heightfield_vertex_encoder (
  input  logic clk,
  input  logic rst,
  hve_vtx_if.sink   vtx,
  hve_res_if.source res,
  hve_cfg_if.sink   cfg
);
  import hve_pkg::*;

  hve_ctrl_t   ctrl;
  hve_status_t status;

  logic [REG_W-1:0]   height_scale;
  logic [REG_W-1:0]   slope_scale;
  logic signed [HEIGHT_W-1:0] ch;
  logic signed [DIFF_W-1:0]   dx;
  logic signed [DIFF_W-1:0]   dy;
  logic signed [HEIGHT_W-1:0] running_min;
  logic signed [HEIGHT_W-1:0] running_max;
  logic [CODE_W-1:0]  hcode;
  logic               axis;
  logic               sat;
  logic [2*REG_W-1:0] d2;
  logic [REG_W-1:0]   tsq;
  logic [2*REG_W-1:0] plo;
  logic [NORM_W-1:0]  m;
  logic [3:0]         bitn;
  logic [CODE_W-1:0]  nx;
  logic [CODE_W-1:0]  ny;
  logic               out_valid;

  logic [REG_W-1:0]   mul_a;
  logic [REG_W-1:0]   mul_b;
  logic [2*REG_W-1:0] prod;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]  mag;
  logic [NORM_W-1:0]  cand;
  logic [CODE_W-1:0]  t;
  logic [REG_W-1:0]   a_coef;
  logic [95:0]        total;
  logic [95:0]        lhs;
  logic [48:0]        code_sum;
  logic [NORM_W-1:0]  nmag;
  logic [CODE_W-1:0]  nval;
  logic signed [HEIGHT_W-1:0] vc;

  hve_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  hve_ctrl u_ctrl (.clk(clk), .rst(rst), .status(status), .ctrl(ctrl));

  assign diff   = axis ? dy : dx;
  assign mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign cand   = m | (NORM_W'(1) << bitn);
  assign t      = {cand, 1'b0} - CODE_W'(1);
  assign a_coef = FOUR_K2 - ((ctrl.op == OP_A_LO) ? prod[REG_W-1:0] : tsq);
  assign total  = {prod, 32'd0} + {32'd0, plo};
  assign lhs    = {16'd0, tsq, 48'd0};
  assign code_sum = {1'b0, prod[REG_W-1:0], 16'd0} - {17'd0, prod[REG_W-1:0]}
                  + 49'h0_8000_0000;
  assign nmag   = sat ? NORM_MAX : m;
  assign nval   = diff[DIFF_W-1] ? CODE_W'(-{1'b0, nmag}) : {1'b0, nmag};
  assign vc     = vtx.center_height;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      OP_HEIGHT: begin
        mul_a = (ch > 0) ? {9'd0, ch[HEIGHT_W-2:0]} : '0;
        mul_b = height_scale;
      end
      OP_SLOPE: begin
        mul_a = {7'd0, mag};
        mul_b = slope_scale;
      end
      OP_SQ_D: begin
        mul_a = prod[REG_W-1:0];
        mul_b = prod[REG_W-1:0];
      end
      OP_SQ_T: begin
        mul_a = {16'd0, t};
        mul_b = {16'd0, t};
      end
      OP_A_LO: begin
        mul_a = a_coef;
        mul_b = d2[REG_W-1:0];
      end
      OP_A_HI: begin
        mul_a = a_coef;
        mul_b = d2[2*REG_W-1:REG_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign status.in_valid = vtx.valid;
  assign status.prod_sat = (prod[2*REG_W-1:REG_W] != '0);
  assign status.last_bit = (bitn == '0);
  assign status.axis     = axis;
  assign status.out_free = !out_valid || res.ready;

  assign vtx.ready = ctrl.in_ready;
  assign cfg.ready = 1'b1;
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_scale <= HEIGHT_SCALE_RST;
      slope_scale  <= SLOPE_SCALE_RST;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_HEIGHT_SCALE) begin
        height_scale <= cfg.data;
      end else if (cfg.index == CFG_SLOPE_SCALE) begin
        slope_scale <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= '0;
      running_max <= '0;
    end else if (ctrl.load_in) begin
      if (vtx.first_vertex) begin
        running_min <= vc;
        running_max <= vc;
      end else begin
        if (vc < running_min) running_min <= vc;
        if (vc > running_max) running_max <= vc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      ch   <= vc;
      dx   <= DIFF_W'(vtx.left_height) - DIFF_W'(vtx.right_height);
      dy   <= DIFF_W'(vtx.up_height) - DIFF_W'(vtx.down_height);
      axis <= 1'b0;
    end
    if (ctrl.cap_hcode) begin
      if (ch <= 0) begin
        hcode <= '0;
      end else if (prod[2*REG_W-1:REG_W] != '0) begin
        hcode <= CODE_MAX;
      end else begin
        hcode <= code_sum[47:32];
      end
    end
    if (ctrl.cap_sat) begin
      sat  <= status.prod_sat;
      m    <= '0;
      bitn <= TOP_BIT;
    end
    if (ctrl.cap_d2) d2 <= prod;
    if (ctrl.cap_tsq) tsq <= prod[REG_W-1:0];
    if (ctrl.cap_plo) plo <= prod;
    if (ctrl.cmp_step) begin
      if (lhs <= total) m <= cand;
      if (bitn != '0) bitn <= bitn - 4'd1;
    end
    if (ctrl.end_axis) begin
      if (axis) begin
        ny <= nval;
      end else begin
        nx <= nval;
      end
      axis <= ~axis;
    end
    if (ctrl.load_out) begin
      res.height_code       <= hcode;
      res.normal_x          <= nx;
      res.normal_y          <= ny;
      res.sector_min_height <= running_min;
      res.sector_max_height <= running_max;
    end
  end

endmodule

// ----- bench/heightfield_vertex_encoder_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the heightfield vertex encoder: a directed table, then
// random vertices under random idling, checked against a bit-exact predictor.
// Depends on hve_pkg, hve_if and the heightfield_vertex_encoder RTL.
module heightfield_vertex_encoder_test;
  import hve_pkg::*;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] c, l, r, u, d;
    logic                       first;
  } vertex_t;

  typedef struct packed {
    logic        [CODE_W-1:0]   code;
    logic signed [CODE_W-1:0]   nx, ny;
    logic signed [HEIGHT_W-1:0] mn, mx;
  } encoded_t;

  typedef struct {
    vertex_t    v;
    logic       known;
    encoded_t   e;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  hve_vtx_if vtx ();
  hve_res_if res ();
  hve_cfg_if cfg ();

  heightfield_vertex_encoder u_top (.clk(clk), .rst(rst), .vtx(vtx), .res(res), .cfg(cfg));

  logic [REG_W-1:0] height_scale_q, slope_scale_q;
  logic signed [HEIGHT_W-1:0] run_min_q, run_max_q;
  encoded_t pending_results[$];
  int failures = 0;
  int results_seen = 0;
  int sink_idle_pct = 29;
  int hold_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("[heightfield_vertex_encoder] ERROR");
    $finish;
  end

  function automatic logic [CODE_W-1:0] height_code_of(logic signed [HEIGHT_W-1:0] h);
    logic [63:0] p;
    logic [63:0] q;
    if (h <= 0) return 16'd0;
    p = 64'(unsigned'(32'(h))) * 64'(height_scale_q);
    if (p >= 64'h1_0000_0000) return CODE_MAX;
    q = (p * 64'd65535 + 64'h8000_0000) >> 32;
    return q[15:0];
  endfunction

  // Largest m with 32767*D/sqrt(D^2+2^48) >= m-1/2, by exact integer comparison.
  function automatic logic signed [CODE_W-1:0] normal_of(logic signed [DIFF_W-1:0] diff);
    logic [31:0] mag;
    logic [63:0] big;
    logic [127:0] d2, lhs, rhs, c, w;
    int lo, hi, mid;
    mag = diff < 0 ? 32'(-diff) : 32'(diff);
    big = 64'(mag) * 64'(slope_scale_q);
    lo = 0;
    hi = 32767;
    if (big >= 64'h1_0000_0000) lo = 32767;
    else if (big != 0) begin
      d2 = 128'(big) * 128'(big);
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        w = 128'(2 * mid - 1);
        c = w * w;
        lhs = c * (d2 + (128'd1 << 48));
        rhs = 128'(64'd4 * 64'd32767 * 64'd32767) * d2;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
    end
    return diff < 0 ? 16'(-lo) : 16'(lo);
  endfunction

  function automatic encoded_t encode_vertex(vertex_t v);
    encoded_t e;
    if (v.first) begin
      run_min_q = v.c;
      run_max_q = v.c;
    end else begin
      if (v.c < run_min_q) run_min_q = v.c;
      if (v.c > run_max_q) run_max_q = v.c;
    end
    e.code = height_code_of(v.c);
    e.nx = normal_of(DIFF_W'(v.l) - DIFF_W'(v.r));
    e.ny = normal_of(DIFF_W'(v.u) - DIFF_W'(v.d));
    e.mn = run_min_q;
    e.mx = run_max_q;
    return e;
  endfunction

  // Leaves valid high; the caller drops it once the last write is done.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == CFG_HEIGHT_SCALE) height_scale_q = val;
    else if (idx == CFG_SLOPE_SCALE) slope_scale_q = val;
  endtask

  // Valid stays high after the beat; it drops on idling or when the caller stops.
  task automatic send_vertex(vertex_t v, logic known, encoded_t want, int idle_pct);
    encoded_t e;
    while ($urandom_range(99) < idle_pct) begin
      vtx.valid <= 1'b0;
      @(posedge clk);
    end
    vtx.valid <= 1'b1;
    {vtx.center_height, vtx.left_height, vtx.right_height, vtx.up_height,
     vtx.down_height, vtx.first_vertex} <= v;
    do @(posedge clk); while (!vtx.ready);
    e = encode_vertex(v);
    if (known && e != want)
      $display("%0t table row disagrees with predictor: %h vs %h", $time, want, e);
    pending_results.insert(pending_results.size(), known ? want : e);
  endtask

  task automatic wait_drained();
    vtx.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  function automatic vertex_t random_vertex(int mode);
    vertex_t v;
    logic signed [HEIGHT_W-1:0] base;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    v = raw[$bits(vertex_t)-1:0];
    base = HEIGHT_W'($urandom);
    if (mode < 7) begin
      v.l = base + HEIGHT_W'($signed($urandom_range(2047)) - 1024);
      v.r = base + HEIGHT_W'($signed($urandom_range(2047)) - 1024);
      v.u = base + HEIGHT_W'($signed($urandom_range(255)) - 128);
      v.d = base + HEIGHT_W'($signed($urandom_range(255)) - 128);
      v.c = HEIGHT_W'($urandom_range(8191));
    end
    v.first = ($urandom_range(15) == 0);
    return v;
  endfunction

  always @(posedge clk) begin
    encoded_t got, want;
    if (!rst && res.valid && res.ready) begin
      got = {res.height_code, res.normal_x, res.normal_y,
             res.sector_min_height, res.sector_max_height};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result beat %h", $time, got);
        failures++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (got.code != want.code || got.nx != want.nx || got.ny != want.ny ||
            got.mn != want.mn || got.mx != want.mx) begin
          $display("%0t mismatch: expected code %0d nx %0d ny %0d min %0d max %0d",
                   $time, want.code, want.nx, want.ny, want.mn, want.mx);
          $display("%0t            actual code %0d nx %0d ny %0d min %0d max %0d",
                   $time, got.code, got.nx, got.ny, got.mn, got.mx);
          failures++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    row_t rows[$];
    row_t row;
    encoded_t z;
    int src_idle;
    logic [REG_W-1:0] hs [4];
    logic [REG_W-1:0] ss [4];
    vtx.valid = 1'b0;
    vtx.center_height = '0;
    vtx.left_height = '0;
    vtx.right_height = '0;
    vtx.up_height = '0;
    vtx.down_height = '0;
    vtx.first_vertex = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    height_scale_q = HEIGHT_SCALE_RST;
    slope_scale_q = SLOPE_SCALE_RST;
    run_min_q = '0;
    run_max_q = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Flat vertex straight after reset, extremes of height and slope.
    z = '0;
    row = '{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b1, z};
    rows.insert(rows.size(), row);
    row = '{'{-24'sd8388608, 24'sd5, 24'sd5, 24'sd9, 24'sd9, 1'b1}, 1'b1,
            '{16'd0, 16'sd0, 16'sd0, -24'sd8388608, -24'sd8388608}};
    rows.insert(rows.size(), row);
    row = '{'{24'sd8388607, 24'sd8388607, -24'sd8388608, -24'sd8388608,
              24'sd8388607, 1'b0}, 1'b1,
            '{CODE_MAX, 16'sd32767, -16'sd32767, -24'sd8388608, 24'sd8388607}};
    rows.insert(rows.size(), row);
    row = '{'{24'sd256, 24'sd256, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, z};
    rows.insert(rows.size(), row);
    row = '{'{24'sd128, 24'sd0, 24'sd1, 24'sd3, 24'sd0, 1'b0}, 1'b0, z};
    rows.insert(rows.size(), row);
    row = '{'{24'sd1, 24'sd512, 24'sd0, 24'sd0, 24'sd512, 1'b0}, 1'b0, z};
    rows.insert(rows.size(), row);
    row = '{'{-24'sd1, -24'sd100, 24'sd100, 24'sd7, -24'sd7, 1'b0}, 1'b0, z};
    rows.insert(rows.size(), row);
    row = '{'{24'sd255, 24'sd0, 24'sd65536, 24'sd65536, 24'sd0, 1'b1}, 1'b0, z};
    rows.insert(rows.size(), row);
    row = '{'{24'sd65535, 24'sd1, 24'sd0, 24'sd0, 24'sd1, 1'b0}, 1'b0, z};
    rows.insert(rows.size(), row);
    row = '{'{24'sh555555, 24'shAAAAAA, 24'sh555555, 24'sh2AAAAA,
              24'shD55555, 1'b0}, 1'b0, z};
    rows.insert(rows.size(), row);
    foreach (rows[i]) send_vertex(rows[i].v, rows[i].known, rows[i].e, 0);
    wait_drained();

    hs = '{32'd0, 32'hFFFF_FFFF, 32'd65536, HEIGHT_SCALE_RST};
    ss = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd3000};
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_HEIGHT_SCALE, hs[phase]);
      write_reg(CFG_SLOPE_SCALE, ss[phase]);
      write_reg(CFG_IDX_W'(2 + phase), $urandom);
      cfg.valid <= 1'b0;
      if (phase == 0) begin
        row.v = '{24'sd300, 24'sd1, 24'sd0, 24'sd0, 24'sd1, 1'b1};
        send_vertex(row.v, 1'b1,
                    '{16'd0, 16'sd32767, -16'sd32767, 24'sd300, 24'sd300}, 0);
        row.v = '{24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0};
        send_vertex(row.v, 1'b1, '{16'd0, 16'sd0, 16'sd0, 24'sd1, 24'sd300}, 0);
      end
      for (int n = 0; n < 470; n++) begin
        src_idle = (n >= 100 && n < 220) ? 0 : 29;
        sink_idle_pct = (n >= 100 && n < 220) ? 0 : 29;
        if (n == 300 && phase == 1) begin
          hold_cycles = 2000;
        end
        if (n == 400 && phase == 2) begin
          vtx.valid <= 1'b0;
          do @(posedge clk); while (pending_results.size() != 0);
        end
        send_vertex(random_vertex($urandom_range(9)), 1'b0, z, src_idle);
      end
      wait_drained();
    end

    $display("Covered %0d result beats over four register settings, including both",
             results_seen);
    $display("scale extremes, saturated slopes and a long receiver hold-off.");
    if (failures == 0) begin
      $display("[heightfield_vertex_encoder] OK");
    end else begin
      $display("[heightfield_vertex_encoder] ERROR");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/hve_pkg.sv
rtl/core/hve_if.sv
rtl/core/hve_mul.sv
rtl/core/hve_ctrl.sv
rtl/core/heightfield_vertex_encoder.sv
bench/heightfield_vertex_encoder_test.sv
